// ===== src/hac_pkg.sv =====
package hac_pkg;

  localparam int VramAddrBits = 16;
  localparam int NumRegs      = 18;
  localparam int RegIdxBits   = 5;
  localparam int AddrWide     = 24;
  localparam int PageBit      = 16;

  localparam logic [RegIdxBits-1:0] RegVerEndBlnk = 5'd5;
  localparam logic [RegIdxBits-1:0] RegVerTotal   = 5'd7;
  localparam logic [RegIdxBits-1:0] RegControl1   = 5'd11;
  localparam logic [RegIdxBits-1:0] RegControl2   = 5'd12;
  localparam logic [RegIdxBits-1:0] RegStatus     = 5'd13;
  localparam logic [RegIdxBits-1:0] RegXyOffset   = 5'd14;
  localparam logic [RegIdxBits-1:0] RegXyAddress  = 5'd15;
  localparam logic [RegIdxBits-1:0] RegVerCounter = 5'd17;

  localparam logic [2:0] OpHostWrite  = 3'd0;
  localparam logic [2:0] OpHostRead   = 3'd1;
  localparam logic [2:0] OpLatchWrite = 3'd2;
  localparam logic [2:0] OpLatchRead  = 3'd3;
  localparam logic [2:0] OpFrameTick  = 3'd4;

  localparam logic [2:0] FnReg0   = 3'd0;
  localparam logic [2:0] FnXy     = 3'd1;
  localparam logic [2:0] FnReg2   = 3'd2;
  localparam logic [2:0] FnDirect = 3'd3;

  typedef enum logic [3:0] {
    KindNop,
    KindRegWr,
    KindRegRd,
    KindXyWr,
    KindXyRd,
    KindDirWr,
    KindDirRd,
    KindLatchWr,
    KindLatchRd,
    KindTick
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              column;
    logic [7:0]              wdata;
    logic [9:0]              scanline;
    logic [VramAddrBits-1:0] dir_addr;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [15:0] reg_default(input logic [RegIdxBits-1:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'h0010;
      5'd1:    v = 16'h0020;
      5'd2:    v = 16'h01f0;
      5'd3:    v = 16'h0200;
      5'd4:    v = 16'h0004;
      5'd5:    v = 16'h0010;
      5'd6:    v = 16'h00f0;
      5'd7:    v = 16'h0100;
      5'd11:   v = 16'h7000;
      5'd12:   v = 16'h0600;
      5'd14:   v = 16'h0010;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] xy_step(input logic [15:0] a, input logic [3:0] code,
                                          input logic [3:0] ps);
    logic [15:0] xm;
    logic [15:0] dy;
    logic [1:0]  xop;
    logic [1:0]  yop;
    logic [15:0] r;
    dy  = 16'(17'd1 << ps);
    xm  = dy - 16'd1;
    xop = code[1:0];
    yop = code[3:2];
    r   = a;
    if (yop == 2'd0) begin
      if (xop == 2'd1) r = a + 16'd1;
      else if (xop == 2'd2) r = a - 16'd1;
      else if (xop == 2'd3) r = a & ~xm;
    end else if (yop == 2'd3) begin
      if (xop == 2'd1) r = a + 16'd1;
      else if (xop == 2'd2) r = a - 16'd1;
      r = (xop == 2'd3) ? 16'd0 : (r & xm);
    end else begin
      if (xop == 2'd1) r = (a & ~xm) | ((a + 16'd1) & xm);
      else if (xop == 2'd2) r = (a & ~xm) | ((a - 16'd1) & xm);
      else if (xop == 2'd3) r = a & ~xm;
      r = (yop == 2'd1) ? (r + dy) : (r - dy);
    end
    return r;
  endfunction

endpackage

// ===== src/hac_front.sv =====
module hac_front (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [39:0]        s_axis_tdata_i,
  input  logic [3:0]         row_shift_i,
  input  hac_pkg::back_stat_t stat_i,
  input  logic               q_full_i,
  output logic               push_o,
  output hac_pkg::item_t     item_o
);
  import hac_pkg::*;

  logic [2:0]          opcode;
  logic [2:0]          fn;
  logic [7:0]          row;
  logic [AddrWide-1:0] dir_wide;
  logic                reg_fn;

  assign opcode = s_axis_tdata_i[2:0];
  assign fn     = s_axis_tdata_i[5:3];
  assign row    = s_axis_tdata_i[21:14];
  assign reg_fn = (fn == FnReg0) || (fn == FnReg2);

  assign s_axis_tready_o = !stat_i.clearing && !q_full_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  assign dir_wide = (AddrWide'(row) << row_shift_i) | AddrWide'(s_axis_tdata_i[13:6]);

  always_comb begin
    item_o.column   = s_axis_tdata_i[13:6];
    item_o.wdata    = s_axis_tdata_i[29:22];
    item_o.scanline = s_axis_tdata_i[39:30];
    item_o.dir_addr = dir_wide[VramAddrBits-1:0];
    item_o.kind     = KindNop;
    unique case (opcode)
      OpHostWrite: begin
        if (reg_fn) item_o.kind = KindRegWr;
        else if (fn == FnXy) item_o.kind = KindXyWr;
        else if (fn == FnDirect) item_o.kind = KindDirWr;
      end
      OpHostRead: begin
        if (reg_fn) item_o.kind = KindRegRd;
        else if (fn == FnXy) item_o.kind = KindXyRd;
        else if (fn == FnDirect) item_o.kind = KindDirRd;
      end
      OpLatchWrite: item_o.kind = KindLatchWr;
      OpLatchRead:  item_o.kind = KindLatchRd;
      OpFrameTick:  item_o.kind = KindTick;
      default:      item_o.kind = KindNop;
    endcase
  end

endmodule

// ===== src/hac_queue.sv =====
module hac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hac_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hac_pkg::item_t item_o
);
  import hac_pkg::*;

  item_t      entries_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wptr_q] <= item_i;
  end

endmodule

// ===== src/hac_back.sv =====
module hac_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hac_pkg::item_t      q_item_i,
  output logic                pop_o,
  output hac_pkg::back_stat_t stat_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o
);
  import hac_pkg::*;

  localparam int VramSize = 1 << VramAddrBits;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StMemRd,
    StDiv
  } state_e;

  state_e                  state_q, state_d;
  logic [15:0]             regs_q [NumRegs];
  logic [15:0]             regs_d [NumRegs];
  logic [3:0]              pitch_q, pitch_d;
  logic [7:0]              latch_q, latch_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              rd_q, rd_d;
  logic                    irq_q, irq_d;
  logic                    hi_q, hi_d;
  logic [15:0]             rem_q, rem_d;
  logic [16:0]             dvd_q, dvd_d;
  logic [4:0]              cnt_q, cnt_d;
  logic [VramAddrBits-1:0] clr_q, clr_d;

  logic [7:0]              pix_mem [VramSize];
  logic [7:0]              lat_mem [VramSize];
  logic [7:0]              pix_rd_q;
  logic                    mem_we;
  logic [VramAddrBits-1:0] mem_addr;
  logic [7:0]              pix_wdata;
  logic [7:0]              lat_wdata;

  logic [5:0]              ridx_full;
  logic [RegIdxBits-1:0]   ridx;
  logic                    ridx_ok;
  logic [15:0]             rval;
  logic [AddrWide-1:0]     xy_wide;
  logic [AddrWide-1:0]     page_wide;
  logic [VramAddrBits-1:0] xy_addr;
  logic [VramAddrBits-1:0] dir_wr_addr;
  logic [16:0]             trial;
  logic [15:0]             rem_next;
  logic [15:0]             div_sum;
  logic                    out_load;
  logic [7:0]              out_val;

  assign ridx_full = q_item_i.column[7:2];
  assign ridx      = ridx_full[RegIdxBits-1:0];
  assign ridx_ok   = ridx_full < 6'(NumRegs);
  assign rval      = ridx_ok ? regs_q[ridx] : 16'hffff;

  assign xy_wide   = AddrWide'({regs_q[RegXyOffset][11:8], regs_q[RegXyAddress]});
  assign xy_addr   = xy_wide[VramAddrBits-1:0];
  assign page_wide = regs_q[RegControl2][6]
                   ? (AddrWide'(regs_q[RegControl2][1:0]) << PageBit) : '0;
  assign dir_wr_addr = q_item_i.dir_addr | page_wide[VramAddrBits-1:0];

  assign trial    = {rem_q, dvd_q[16]};
  assign div_sum  = 16'(trial - {1'b0, regs_q[RegVerTotal]});
  assign rem_next = (trial >= {1'b0, regs_q[RegVerTotal]}) ? div_sum : trial[15:0];

  always_comb begin
    regs_d      = regs_q;
    pitch_d     = pitch_q;
    latch_d     = latch_q;
    state_d     = state_q;
    hi_d        = hi_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = xy_addr;
    pix_wdata   = q_item_i.wdata;
    lat_wdata   = latch_q;
    out_load    = 1'b0;
    out_val     = 8'd0;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        pix_wdata = 8'd0;
        lat_wdata = 8'd0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) state_d = StIdle;
      end
      StIdle: begin
        if (q_valid_i && !out_valid_q) begin
          pop_o = 1'b1;
          unique case (q_item_i.kind)
            KindRegWr: begin
              out_load = 1'b1;
              if (ridx_ok) begin
                if (q_item_i.column[1]) regs_d[ridx][15:8] = q_item_i.wdata;
                else regs_d[ridx][7:0] = q_item_i.wdata;
                if (ridx == RegXyOffset) begin
                  for (int k = 0; k < 8; k++) begin
                    if (regs_d[RegXyOffset][7:0] == 8'(1 << k)) pitch_d = 4'(k + 2);
                  end
                end
              end
            end
            KindRegRd: begin
              if (ridx == RegStatus && ridx_ok) regs_d[RegStatus] = 16'd0;
              if (ridx == RegVerCounter && ridx_ok) begin
                if (regs_q[RegVerTotal] == 16'd0) begin
                  out_load = 1'b1;
                end else begin
                  dvd_d   = 17'(q_item_i.scanline) + 17'(regs_q[RegVerEndBlnk]);
                  rem_d   = 16'd0;
                  cnt_d   = 5'd0;
                  hi_d    = q_item_i.column[1];
                  state_d = StDiv;
                end
              end else begin
                out_load = 1'b1;
                out_val  = q_item_i.column[1] ? rval[15:8] : rval[7:0];
              end
            end
            KindXyWr, KindXyRd: begin
              if (q_item_i.column != 8'd0) begin
                regs_d[RegXyAddress] = xy_step(regs_q[RegXyAddress],
                                               q_item_i.column[4:1], pitch_q);
              end
              if (q_item_i.kind == KindXyWr) begin
                mem_we   = 1'b1;
                out_load = 1'b1;
              end else begin
                state_d = StMemRd;
              end
            end
            KindDirWr: begin
              mem_addr = dir_wr_addr;
              mem_we   = 1'b1;
              out_load = 1'b1;
            end
            KindDirRd: begin
              mem_addr = q_item_i.dir_addr;
              state_d  = StMemRd;
            end
            KindLatchWr: begin
              latch_d  = q_item_i.wdata;
              out_load = 1'b1;
            end
            KindLatchRd: begin
              out_load = 1'b1;
              out_val  = latch_q;
            end
            KindTick: begin
              regs_d[RegStatus][0] = 1'b1;
              out_load = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      StMemRd: begin
        out_load = 1'b1;
        out_val  = pix_rd_q;
        state_d  = StIdle;
      end
      StDiv: begin
        rem_d = rem_next;
        dvd_d = {dvd_q[15:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          out_load = 1'b1;
          out_val  = hi_q ? rem_next[15:8] : rem_next[7:0];
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
    rd_d        = out_load ? out_val : rd_q;
    irq_d       = out_load ? (regs_d[RegStatus][0] && regs_d[RegControl1][10]) : irq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= reg_default(RegIdxBits'(i));
      pitch_q     <= 4'd0;
      latch_q     <= 8'd0;
      out_valid_q <= 1'b0;
      rd_q        <= 8'd0;
      irq_q       <= 1'b0;
      hi_q        <= 1'b0;
      rem_q       <= 16'd0;
      dvd_q       <= 17'd0;
      cnt_q       <= 5'd0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      regs_q      <= regs_d;
      pitch_q     <= pitch_d;
      latch_q     <= latch_d;
      out_valid_q <= out_valid_d;
      rd_q        <= rd_d;
      irq_q       <= irq_d;
      hi_q        <= hi_d;
      rem_q       <= rem_d;
      dvd_q       <= dvd_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= pix_wdata;
      lat_mem[mem_addr] <= lat_wdata;
    end
    pix_rd_q <= pix_mem[mem_addr];
  end

  assign stat_o.clearing = state_q == StClear;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, irq_q, rd_q};

endmodule

// ===== src/video_controller_host_access.sv =====
// Channel   Dir  Beat content (lowest bit first)
// s_axis    in   opcode, function_code, column, row, write_data, scanline
// m_axis    out  read_data, interrupt_line
// cfg       in   row_shift
//
// Most beats go from the queue straight into the output register; pixel reads first pass the memory read register.
// Vertical counter reads with a nonzero vertical total first pass a bit-serial remainder unit.
// After reset the pixel and latch memories are cleared,
// and no beat is accepted until the clear is done.
// A two-entry queue and an output register let both sides stall independently.
module video_controller_host_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], function_code[5:3], column[13:6], row[21:14],
  // write_data[29:22], scanline[39:30]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], interrupt_line[8]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);
  import hac_pkg::*;

  logic [3:0] rs_q;
  back_stat_t stat;
  item_t      push_item;
  item_t      q_item;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rs_q <= 4'd8;
    else if (cfg_we_i) rs_q <= cfg_wdata_i;
  end

  hac_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .row_shift_i     (rs_q),
    .stat_i          (stat),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  hac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  hac_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .stat_o          (stat),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

// ===== verif/video_controller_host_access_tb.sv =====
`timescale 1ns / 100ps

module video_controller_host_access_tb;
  import hac_pkg::*;

  localparam int WatchdogLimit = 400000;
  localparam int SettleCycles  = 40;
  localparam logic [1:0] StepNone = 2'd0;
  localparam logic [1:0] StepInc  = 2'd1;
  localparam logic [1:0] StepDec  = 2'd2;
  localparam logic [1:0] StepZero = 2'd3;

  typedef struct packed {
    logic [9:0] scanline;
    logic [7:0] wdata;
    logic [7:0] row;
    logic [7:0] column;
    logic [2:0] fn;
    logic [2:0] op;
  } access_t;

  typedef struct packed {
    logic       irq;
    logic [7:0] rdata;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;

  logic [15:0] ctl_regs [NumRegs];
  logic [7:0]  pixel_ram [1 << VramAddrBits];
  logic [7:0]  latch_ram [1 << VramAddrBits];
  logic [7:0]  latch_val;
  logic [3:0]  pitch_val;
  logic [3:0]  row_shift_val;

  reply_t      pending_replies[$];
  int          err_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          recv_hold;
  int          quiet_cycles;

  video_controller_host_access uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic [15:0] xy_advance(input logic [15:0] a, input logic [3:0] code);
    logic [15:0] xm;
    logic [15:0] dy;
    logic [1:0]  xs;
    logic [1:0]  ys;
    dy = 16'(32'd1 << pitch_val);
    xm = dy - 16'd1;
    xs = code[1:0];
    ys = code[3:2];
    if (ys == StepNone) begin
      if (xs == StepInc) a = a + 16'd1;
      else if (xs == StepDec) a = a - 16'd1;
      else if (xs == StepZero) a = a & ~xm;
    end else if (ys == StepZero) begin
      if (xs == StepInc) a = a + 16'd1;
      else if (xs == StepDec) a = a - 16'd1;
      a = (xs == StepZero) ? 16'd0 : (a & xm);
    end else begin
      if (xs == StepInc) a = (a & ~xm) | ((a + 16'd1) & xm);
      else if (xs == StepDec) a = (a & ~xm) | ((a - 16'd1) & xm);
      else if (xs == StepZero) a = a & ~xm;
      a = (ys == StepInc) ? (a + dy) : (a - dy);
    end
    return a;
  endfunction

  function automatic logic [VramAddrBits-1:0] xy_pixel_addr(input logic [7:0] column);
    logic [31:0] p;
    p = {16'd0, ctl_regs[RegXyAddress]};
    if (column != 8'd0) ctl_regs[RegXyAddress] = xy_advance(ctl_regs[RegXyAddress], column[4:1]);
    p = p | ({16'd0, ctl_regs[RegXyOffset] & 16'h0f00} << 8);
    return p[VramAddrBits-1:0];
  endfunction

  function automatic void write_reg_half(input logic [7:0] column, input logic [7:0] data);
    int r;
    r = column[7:2];
    if (r < NumRegs) begin
      if (column[1]) ctl_regs[r][15:8] = data;
      else ctl_regs[r][7:0] = data;
      if (r == RegXyOffset) begin
        for (int k = 0; k < 8; k++) begin
          if (ctl_regs[RegXyOffset][7:0] == 8'(1 << k)) pitch_val = 4'(k + 2);
        end
      end
    end
  endfunction

  function automatic logic [7:0] read_reg_half(input logic [7:0] column, input logic [9:0] sl);
    int r;
    logic [31:0] v;
    logic [31:0] total;
    r = column[7:2];
    v = (r < NumRegs) ? {16'd0, ctl_regs[r]} : 32'h0000ffff;
    if (r == RegStatus) begin
      ctl_regs[RegStatus] = 16'd0;
    end else if (r == RegVerCounter) begin
      total = {16'd0, ctl_regs[RegVerTotal]};
      v = (total != 0) ? (({22'd0, sl} + {16'd0, ctl_regs[RegVerEndBlnk]}) % total) : 32'd0;
    end
    return column[1] ? v[15:8] : v[7:0];
  endfunction

  function automatic reply_t predict_access(input access_t b);
    reply_t      res;
    logic [31:0] a;
    res.rdata = 8'd0;
    if (b.op == OpHostWrite) begin
      if (b.fn == FnReg0 || b.fn == FnReg2) begin
        write_reg_half(b.column, b.wdata);
      end else if (b.fn == FnXy || b.fn == FnDirect) begin
        if (b.fn == FnXy) begin
          a = {16'd0, xy_pixel_addr(b.column)};
        end else begin
          a = ({24'd0, b.row} << row_shift_val) | {24'd0, b.column};
          if (ctl_regs[RegControl2][6]) a = a | ({30'd0, ctl_regs[RegControl2][1:0]} << 16);
        end
        pixel_ram[a[VramAddrBits-1:0]] = b.wdata;
        latch_ram[a[VramAddrBits-1:0]] = latch_val;
      end
    end else if (b.op == OpHostRead) begin
      if (b.fn == FnReg0 || b.fn == FnReg2) begin
        res.rdata = read_reg_half(b.column, b.scanline);
      end else if (b.fn == FnXy) begin
        res.rdata = pixel_ram[xy_pixel_addr(b.column)];
      end else if (b.fn == FnDirect) begin
        a = ({24'd0, b.row} << row_shift_val) | {24'd0, b.column};
        res.rdata = pixel_ram[a[VramAddrBits-1:0]];
      end
    end else if (b.op == OpLatchWrite) begin
      latch_val = b.wdata;
    end else if (b.op == OpLatchRead) begin
      res.rdata = latch_val;
    end else if (b.op == OpFrameTick) begin
      ctl_regs[RegStatus][0] = 1'b1;
    end
    res.irq = ctl_regs[RegStatus][0] & ctl_regs[RegControl1][10];
    return res;
  endfunction

  task automatic send_access(input access_t b);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(predict_access(b));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_row_shift(input logic [3:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    row_shift_val = v;
    @(posedge clk_i);
  endtask

  function automatic access_t mk(input logic [2:0] op, input logic [2:0] fn,
                                 input logic [7:0] col, input logic [7:0] row,
                                 input logic [7:0] wd, input logic [9:0] sl);
    access_t b;
    b.op = op;
    b.fn = fn;
    b.column = col;
    b.row = row;
    b.wdata = wd;
    b.scanline = sl;
    return b;
  endfunction

  function automatic access_t random_access();
    access_t b;
    int      p;
    b = 40'($urandom);
    b.scanline = 10'($urandom_range(1023));
    p = $urandom_range(99);
    if (p < 40) b.op = OpHostWrite;
    else if (p < 75) b.op = OpHostRead;
    else if (p < 83) b.op = OpLatchWrite;
    else if (p < 90) b.op = OpLatchRead;
    else if (p < 97) b.op = OpFrameTick;
    else b.op = 3'($urandom_range(5, 7));
    p = $urandom_range(99);
    if (p < 20) b.fn = FnReg0;
    else if (p < 35) b.fn = FnReg2;
    else if (p < 65) b.fn = FnXy;
    else if (p < 92) b.fn = FnDirect;
    else b.fn = 3'($urandom_range(4, 7));
    if ((b.fn == FnReg0 || b.fn == FnReg2) && $urandom_range(9) != 0) begin
      b.column[7:2] = 6'($urandom_range(NumRegs - 1));
      if (b.column[7:2] == RegVerTotal && b.op == OpHostWrite && b.column[1])
        b.wdata = 8'($urandom_range(3));
    end
    return b;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_access(mk(OpLatchWrite, FnReg0, 8'h00, 8'h00, 8'hff, 10'd0));
    send_access(mk(OpLatchRead, FnReg0, 8'h00, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostWrite, FnXy, 8'h00, 8'h00, 8'h5a, 10'd0));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegXyOffset, 2'b00}, 8'h00, 8'h01, 10'd0));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegXyOffset, 2'b00}, 8'h00, 8'h03, 10'd0));
    send_access(mk(OpHostWrite, FnReg2, {1'b0, RegXyAddress, 2'b00}, 8'h00, 8'hff, 10'd0));
    send_access(mk(OpHostWrite, FnXy, {3'd0, StepZero, StepInc, 1'b0}, 8'h00, 8'ha5, 10'd0));
    send_access(mk(OpHostWrite, FnXy, {3'd0, StepDec, StepDec, 1'b0}, 8'h00, 8'h11, 10'd0));
    send_access(mk(OpHostRead, FnXy, {3'd0, StepZero, StepZero, 1'b0}, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegXyOffset, 2'b00}, 8'h00, 8'h80, 10'd0));
    send_access(mk(OpHostWrite, FnXy, {3'd0, StepInc, StepNone, 1'b0}, 8'h00, 8'h22, 10'd0));
    send_access(mk(OpHostRead, FnXy, 8'hff, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegControl2, 2'b00}, 8'h00, 8'h43, 10'd0));
    send_access(mk(OpHostWrite, FnDirect, 8'hff, 8'hff, 8'h77, 10'd0));
    send_access(mk(OpHostRead, FnDirect, 8'hff, 8'hff, 8'h00, 10'd0));
    send_access(mk(OpHostWrite, FnReg2, {1'b0, RegControl1, 2'b10}, 8'h00, 8'h04, 10'd0));
    send_access(mk(OpFrameTick, FnReg0, 8'h00, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostRead, FnReg0, {1'b0, RegStatus, 2'b00}, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostRead, FnReg2, {1'b0, RegVerCounter, 2'b00}, 8'h00, 8'h00,
                   10'd1023));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegVerTotal, 2'b10}, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostWrite, FnReg0, {1'b0, RegVerTotal, 2'b00}, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostRead, FnReg0, {1'b0, RegVerCounter, 2'b10}, 8'h00, 8'h00,
                   10'd1023));
    send_access(mk(OpHostWrite, FnReg0, 8'hff, 8'h00, 8'hff, 10'd0));
    send_access(mk(OpHostRead, FnReg2, 8'hfe, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpFrameTick, FnReg0, 8'h00, 8'h00, 8'h00, 10'd0));
    send_access(mk(OpHostRead, FnReg0, 8'hb4, 8'h00, 8'h00, 10'd0));
    send_access(mk(3'd7, 3'd7, 8'hff, 8'hff, 8'hff, 10'd1023));
    stop_sending();
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_access(random_access());
    stop_sending();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 300;
    repeat (40) send_access(random_access());
    stop_sending();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    repeat (20) send_access(random_access());
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) send_access(random_access());
    stop_sending();
  endtask

  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 0);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[7:0] != want.rdata)
          report_mismatch("read_data", m_axis_tdata[7:0], want.rdata);
        if (m_axis_tdata[8] != want.irq)
          report_mismatch("interrupt_line", m_axis_tdata[8], want.irq);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 4'd0;
    err_cnt       = 0;
    recv_hold     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < NumRegs; i++) ctl_regs[i] = reg_default(5'(i));
    for (int i = 0; i < (1 << VramAddrBits); i++) begin
      pixel_ram[i] = 8'd0;
      latch_ram[i] = 8'd0;
    end
    latch_val     = 8'd0;
    pitch_val     = 4'd0;
    row_shift_val = 4'd8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_row_shift(4'd0);
    test_random(500, 36, 58);
    set_row_shift(4'd12);
    test_random(500, 58, 36);
    set_row_shift(4'd3);
    test_random(420, 0, 0);
    set_row_shift(4'd7);
    test_backpressure();
    test_drain_pause();
    wait_drained();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
